### rtl/onfsm_pkg.sv
package onfsm_pkg;

  // configuration register file
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IFACE_KIND = 2'd0,
    REG_OWN_ADDR   = 2'd1,
    REG_NBR_ADDR   = 2'd2
  } cfg_reg_e;

  // interface kinds
  localparam logic [2:0] IFACE_BCAST = 3'd0;
  localparam logic [2:0] IFACE_NBMA  = 3'd1;
  localparam logic [2:0] IFACE_P2P   = 3'd2;
  localparam logic [2:0] IFACE_P2MP  = 3'd3;
  localparam logic [2:0] IFACE_VLINK = 3'd4;

  // neighbor events; 0, 14 and 15 carry no event
  typedef enum logic [3:0] {
    EV_NONE        = 4'd0,
    EV_HELLO       = 4'd1,
    EV_START       = 4'd2,
    EV_TWOWAY      = 4'd3,
    EV_NEG_DONE    = 4'd4,
    EV_EXCH_DONE   = 4'd5,
    EV_BAD_LSREQ   = 4'd6,
    EV_LOAD_DONE   = 4'd7,
    EV_ADJ_OK      = 4'd8,
    EV_SEQ_MISMTCH = 4'd9,
    EV_ONEWAY      = 4'd10,
    EV_KILL        = 4'd11,
    EV_INACTIVITY  = 4'd12,
    EV_LL_DOWN     = 4'd13
  } ev_e;

  localparam logic [2:0] DESC_FLAGS_ALL = 3'd7;

  localparam int CMDQ_DEPTH = 2;
  localparam int OUTQ_DEPTH = 2;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [31:0] iface_dr;
    logic [31:0] iface_bdr;
    logic [31:0] nbr_dr;
    logic [31:0] nbr_bdr;
    logic [31:0] time_now;
    logic        request_list_empty;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  new_state;
    logic        send_dd;
    logic        build_summary;
    logic        send_ls_request;
    logic        restart_inactivity;
    logic        clear_lists;
    logic        regen_router_lsa;
    logic        neighbor_change;
    logic        ddretx_timer_on;
    logic [31:0] desc_seq_num;
    logic [2:0]  desc_flag_bits;
  } out_item_t;

  // classified event handed from front to back
  typedef struct packed {
    ev_e         ev;
    logic        adj;
    logic        req_empty;
    logic [31:0] time_now;
  } cmd_t;

endpackage

### rtl/onfsm_front.sv
module onfsm_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [onfsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                       cfg_data,
  input  logic                              push,
  output logic                              full,
  input  onfsm_pkg::in_item_t               in_data,
  output logic                              cq_wr,
  input  logic                              cq_full,
  output onfsm_pkg::cmd_t                   cq_data
);
  import onfsm_pkg::*;

  logic [2:0]  iface_kind_r;
  logic [31:0] own_addr_r;
  logic [31:0] nbr_addr_r;
  logic        kind_adj;
  logic        addr_adj;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iface_kind_r <= IFACE_BCAST;
      own_addr_r   <= '0;
      nbr_addr_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_IFACE_KIND: iface_kind_r <= cfg_data[2:0];
        REG_OWN_ADDR:   own_addr_r   <= cfg_data;
        REG_NBR_ADDR:   nbr_addr_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // point-to-point style links always form adjacencies; NBMA and broadcast
  // only with DR/BDR
  always_comb begin
    unique case (iface_kind_r)
      IFACE_P2P, IFACE_P2MP, IFACE_VLINK: kind_adj = 1'b1;
      IFACE_BCAST, IFACE_NBMA:            kind_adj = 1'b0;
      default:                            kind_adj = 1'b0;
    endcase
  end

  assign addr_adj = (own_addr_r == in_data.iface_dr) || (own_addr_r == in_data.iface_bdr) ||
                    (nbr_addr_r == in_data.nbr_dr)   || (nbr_addr_r == in_data.nbr_bdr);

  assign full  = cq_full;
  assign cq_wr = push && !cq_full;

  always_comb begin
    cq_data.ev        = ev_e'(in_data.opcode);
    cq_data.adj       = kind_adj || addr_adj;
    cq_data.req_empty = in_data.request_list_empty;
    cq_data.time_now  = in_data.time_now;
  end

endmodule

### rtl/onfsm_cmd_q.sv
module onfsm_cmd_q (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  onfsm_pkg::cmd_t wr_data,
  output logic            full,
  input  logic            rd_en,
  output onfsm_pkg::cmd_t rd_data,
  output logic            empty
);
  import onfsm_pkg::*;

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             slot_r [CMDQ_DEPTH];
  logic [PTR_W-1:0] wp_r;
  logic [PTR_W-1:0] rp_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr;
  logic             do_rd;

  assign full    = (cnt_r == CNT_W'(CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        slot_r[wp_r] <= wr_data;
        wp_r <= (wp_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= (rp_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CMDQ_DEPTH))
    else $error("command queue overfilled");

  a_cnt_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && !do_rd) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("command queue count missed a write");
`endif

endmodule

### rtl/onfsm_back.sv
module onfsm_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cq_empty,
  input  onfsm_pkg::cmd_t      cq_data,
  output logic                 cq_rd,
  output logic                 empty,
  input  logic                 pop,
  output onfsm_pkg::out_item_t out_data
);
  import onfsm_pkg::*;

  typedef enum logic [3:0] {
    ST_DUMMY    = 4'd0,
    ST_DOWN     = 4'd1,
    ST_ATTEMPT  = 4'd2,
    ST_INIT     = 4'd3,
    ST_TWOWAY   = 4'd4,
    ST_EXSTART  = 4'd5,
    ST_EXCHANGE = 4'd6,
    ST_LOADING  = 4'd7,
    ST_FULL     = 4'd8
  } nbr_st_t;

  localparam int PTR_W = (OUTQ_DEPTH > 1) ? $clog2(OUTQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

  nbr_st_t          state_r;
  nbr_st_t          state_nxt;
  logic [31:0]      seq_r;
  logic [31:0]      seq_nxt;
  logic [2:0]       flags_r;
  logic [2:0]       flags_nxt;
  out_item_t        res_r [OUTQ_DEPTH];
  out_item_t        res;
  logic [PTR_W-1:0] wp_r;
  logic [PTR_W-1:0] rp_r;
  logic [CNT_W-1:0] cnt_r;
  logic             take;
  logic             pop_ok;
  logic [31:0]      seq_seed;
  logic             in_range;

  assign empty    = (cnt_r == '0);
  assign pop_ok   = pop && !empty;
  assign take     = !cq_empty && ((cnt_r != CNT_W'(OUTQ_DEPTH)) || pop_ok);
  assign cq_rd    = take;
  assign out_data = res_r[rp_r];

  // zero sequence number is seeded from the clock, else counts up
  assign seq_seed = (seq_r == '0) ? cq_data.time_now : seq_r + 32'd1;
  assign in_range = (state_r >= ST_DOWN) && (state_r <= ST_FULL);

  always_comb begin
    state_nxt = state_r;
    seq_nxt   = seq_r;
    flags_nxt = flags_r;
    res       = '0;
    if (in_range) begin
      unique case (cq_data.ev)
        EV_HELLO: begin
          res.restart_inactivity = 1'b1;
          if (state_r <= ST_INIT) state_nxt = ST_INIT;
        end
        EV_START: begin
          if (state_r == ST_DOWN) state_nxt = ST_ATTEMPT;
        end
        EV_TWOWAY: begin
          if (state_r == ST_INIT) begin
            if (cq_data.adj) begin
              state_nxt   = ST_EXSTART;
              seq_nxt     = seq_seed;
              res.send_dd = 1'b1;
            end else begin
              state_nxt = ST_TWOWAY;
            end
          end
        end
        EV_NEG_DONE: begin
          if (state_r == ST_EXSTART) begin
            state_nxt         = ST_EXCHANGE;
            res.build_summary = 1'b1;
          end
        end
        EV_EXCH_DONE: begin
          if (state_r == ST_EXCHANGE) begin
            if (cq_data.req_empty) begin
              state_nxt = ST_FULL;
            end else begin
              state_nxt           = ST_LOADING;
              res.send_ls_request = 1'b1;
            end
          end
        end
        EV_BAD_LSREQ, EV_SEQ_MISMTCH: begin
          if (state_r >= ST_EXCHANGE) begin
            state_nxt = ST_EXSTART;
            flags_nxt = DESC_FLAGS_ALL;
          end
        end
        EV_LOAD_DONE: begin
          if (state_r == ST_LOADING) state_nxt = ST_FULL;
        end
        EV_ADJ_OK: begin
          if (state_r == ST_TWOWAY && cq_data.adj) begin
            state_nxt   = ST_EXSTART;
            seq_nxt     = seq_seed;
            res.send_dd = 1'b1;
          end else if (state_r >= ST_EXSTART && !cq_data.adj) begin
            state_nxt = ST_TWOWAY;
          end
        end
        EV_ONEWAY: begin
          if (state_r >= ST_TWOWAY) state_nxt = ST_INIT;
        end
        EV_KILL, EV_LL_DOWN: begin
          state_nxt = ST_DOWN;
        end
        EV_INACTIVITY: begin
          state_nxt       = ST_DOWN;
          res.clear_lists = 1'b1;
          flags_nxt       = DESC_FLAGS_ALL;
        end
        default: ;
      endcase
    end
    res.new_state        = state_nxt;
    res.regen_router_lsa = (state_r == ST_FULL) != (state_nxt == ST_FULL);
    res.neighbor_change  = (state_r >= ST_TWOWAY) != (state_nxt >= ST_TWOWAY);
    res.ddretx_timer_on  = (state_nxt == ST_EXSTART);
    res.desc_seq_num     = seq_nxt;
    res.desc_flag_bits   = flags_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_DOWN;
      seq_r   <= '0;
      flags_r <= DESC_FLAGS_ALL;
      wp_r    <= '0;
      rp_r    <= '0;
      cnt_r   <= '0;
    end else begin
      if (take) begin
        state_r     <= state_nxt;
        seq_r       <= seq_nxt;
        flags_r     <= flags_nxt;
        res_r[wp_r] <= res;
        wp_r <= (wp_r == PTR_W'(OUTQ_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop_ok) begin
        rp_r <= (rp_r == PTR_W'(OUTQ_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (take && !pop_ok) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop_ok && !take) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r >= ST_DOWN) && (state_r <= ST_FULL))
    else $error("neighbor state left Down..Full");

  a_seq_only_on_dd: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (seq_nxt != seq_r)) |-> res.send_dd)
    else $error("sequence number moved without a DD send");

  a_outq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(OUTQ_DEPTH))
    else $error("result queue overfilled");
`endif

endmodule

### rtl/ospf_neighbor_fsm_core.sv
// A transaction accepted by the front is filed in the command queue; the transition step
// then moves it into the result queue, from which it can be popped. A full result queue
// holds the transition step back until the receiver pops.
// Throughput: one event per cycle, sustained while the result queue has room or is popped.
// Reset (rst_n low, synchronous): neighbor state Down, DD sequence number zero,
// DD flags all set, configuration registers zero, both queues emptied.
module ospf_neighbor_fsm_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write channel, always ready
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [onfsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                       cfg_data,
  // event input, queue style
  input  logic                              push,
  output logic                              full,
  input  onfsm_pkg::in_item_t               in_data,
  // result output, queue style
  output logic                              empty,
  input  logic                              pop,
  output onfsm_pkg::out_item_t              out_data
);
  import onfsm_pkg::*;

  // front -> command queue -> back
  cmd_t cq_wr_data;
  cmd_t cq_rd_data;
  logic cq_wr;
  logic cq_full;
  logic cq_rd;
  logic cq_empty;

  // Front: holds the interface registers, works out the adjacency flag
  // against the DR/BDR fields of each transaction and files the classified
  // event in the command queue.
  onfsm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cq_wr     (cq_wr),
    .cq_full   (cq_full),
    .cq_data   (cq_wr_data)
  );

  // Short queue decoupling the two halves; each side stalls on its own.
  onfsm_cmd_q u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cq_wr),
    .wr_data (cq_wr_data),
    .full    (cq_full),
    .rd_en   (cq_rd),
    .rd_data (cq_rd_data),
    .empty   (cq_empty)
  );

  // Back: neighbor state, DD sequence number and flags; one transition per
  // cycle into a two-entry result queue, so a waiting result never blocks
  // the next event while there is room.
  onfsm_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cq_empty (cq_empty),
    .cq_data  (cq_rd_data),
    .cq_rd    (cq_rd),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

### tb/ospf_neighbor_fsm_core_test.sv
`timescale 1ns / 100ps

module ospf_neighbor_fsm_core_test;
  import onfsm_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 11;
  localparam int RX_HOLD_CYCLES = 300;   // long receiver hold-off, fills both queues
  localparam int SETTLE_CYCLES  = 8;     // margin on top of the block latency
  localparam int TIMEOUT_CYCLES = 400_000;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_EVENTS   = 200;
  localparam int PRESSURE_EVENTS = 40;

  // kinds outside the defined set; these must not force adjacency
  localparam logic [2:0] IFACE_UNDEF_LO = 3'd5;
  localparam logic [2:0] IFACE_UNDEF_HI = 3'd7;

  // addresses for the directed part; all-zero and all-ones never match them
  localparam logic [31:0] OWN_A   = 32'h0A00_0001;
  localparam logic [31:0] NBR_A   = 32'h0A00_0002;
  localparam logic [31:0] OTHER_A = 32'hC0A8_0101;

  typedef enum logic [3:0] {
    NS_DUMMY    = 4'd0,
    NS_DOWN     = 4'd1,
    NS_ATTEMPT  = 4'd2,
    NS_INIT     = 4'd3,
    NS_TWOWAY   = 4'd4,
    NS_EXSTART  = 4'd5,
    NS_EXCHANGE = 4'd6,
    NS_LOADING  = 4'd7,
    NS_FULL     = 4'd8
  } nbr_state_e;

  // Tracks the neighbour state machine and holds the results it still owes.
  class nbr_fsm_tracker;
    logic [2:0]  kind;
    logic [31:0] own;
    logic [31:0] nbr;
    nbr_state_e  state;
    logic [31:0] seq;
    logic [2:0]  flags;
    out_item_t   expected_steps[$];
    int          mismatches;
    int          n_checked;

    function void reset_model();
      kind  = IFACE_BCAST;
      own   = '0;
      nbr   = '0;
      state = NS_DOWN;
      seq   = '0;
      flags = DESC_FLAGS_ALL;
      expected_steps.delete();
      mismatches = 0;
      n_checked  = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [31:0] val);
      case (idx)
        REG_IFACE_KIND: kind = val[2:0];
        REG_OWN_ADDR:   own  = val;
        REG_NBR_ADDR:   nbr  = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_steps.size();
    endfunction

    // zero sequence number is seeded from the clock, otherwise it counts on (wraps)
    function void seed_seq(logic [31:0] now);
      seq = (seq == '0) ? now : seq + 32'd1;
    endfunction

    function void note_event(in_item_t it);
      out_item_t  r;
      nbr_state_e prev;
      nbr_state_e nxt;
      ev_e        ev;
      logic       adj;
      ev   = ev_e'(it.opcode);
      prev = state;
      nxt  = prev;
      r    = '0;
      adj  = (kind == IFACE_P2P) || (kind == IFACE_P2MP) || (kind == IFACE_VLINK) ||
             (own == it.iface_dr) || (own == it.iface_bdr) ||
             (nbr == it.nbr_dr) || (nbr == it.nbr_bdr);
      if (prev >= NS_DOWN && prev <= NS_FULL) begin
        case (ev)
          EV_HELLO: begin
            r.restart_inactivity = 1'b1;
            if (prev <= NS_INIT) nxt = NS_INIT;
          end
          EV_START: if (prev == NS_DOWN) nxt = NS_ATTEMPT;
          EV_TWOWAY: if (prev == NS_INIT) begin
            if (adj) begin
              nxt = NS_EXSTART;
              seed_seq(it.time_now);
              r.send_dd = 1'b1;
            end else begin
              nxt = NS_TWOWAY;
            end
          end
          EV_NEG_DONE: if (prev == NS_EXSTART) begin
            nxt = NS_EXCHANGE;
            r.build_summary = 1'b1;
          end
          EV_EXCH_DONE: if (prev == NS_EXCHANGE) begin
            if (it.request_list_empty) begin
              nxt = NS_FULL;
            end else begin
              nxt = NS_LOADING;
              r.send_ls_request = 1'b1;
            end
          end
          EV_BAD_LSREQ, EV_SEQ_MISMTCH: if (prev >= NS_EXCHANGE) begin
            nxt   = NS_EXSTART;
            flags = DESC_FLAGS_ALL;
          end
          EV_LOAD_DONE: if (prev == NS_LOADING) nxt = NS_FULL;
          EV_ADJ_OK: begin
            if (prev == NS_TWOWAY && adj) begin
              nxt = NS_EXSTART;
              seed_seq(it.time_now);
              r.send_dd = 1'b1;
            end else if (prev >= NS_EXSTART && !adj) begin
              nxt = NS_TWOWAY;
            end
          end
          EV_ONEWAY: if (prev >= NS_TWOWAY) nxt = NS_INIT;
          EV_KILL, EV_LL_DOWN: nxt = NS_DOWN;
          EV_INACTIVITY: begin
            nxt   = NS_DOWN;
            r.clear_lists = 1'b1;
            flags = DESC_FLAGS_ALL;
          end
          default: ;   // no event: nothing moves
        endcase
      end
      r.regen_router_lsa = (prev == NS_FULL) != (nxt == NS_FULL);
      r.neighbor_change  = (prev >= NS_TWOWAY) != (nxt >= NS_TWOWAY);
      r.new_state        = nxt;
      r.ddretx_timer_on  = (nxt == NS_EXSTART);
      r.desc_seq_num     = seq;
      r.desc_flag_bits   = flags;
      state = nxt;
      expected_steps.push_back(r);
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch on %s (result %0d): expected %h, got %h",
                   $realtime, name, n_checked, want, got);
      end
    endfunction

    function void check_step(out_item_t got);
      out_item_t want;
      if (expected_steps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing outstanding: %h", $realtime, got);
        return;
      end
      want = expected_steps.pop_front();
      n_checked++;
      cmp_field("new_state",          want.new_state,          got.new_state);
      cmp_field("send_dd",            want.send_dd,            got.send_dd);
      cmp_field("build_summary",      want.build_summary,      got.build_summary);
      cmp_field("send_ls_request",    want.send_ls_request,    got.send_ls_request);
      cmp_field("restart_inactivity", want.restart_inactivity, got.restart_inactivity);
      cmp_field("clear_lists",        want.clear_lists,        got.clear_lists);
      cmp_field("regen_router_lsa",   want.regen_router_lsa,   got.regen_router_lsa);
      cmp_field("neighbor_change",    want.neighbor_change,    got.neighbor_change);
      cmp_field("ddretx_timer_on",    want.ddretx_timer_on,    got.ddretx_timer_on);
      cmp_field("desc_seq_num",       want.desc_seq_num,       got.desc_seq_num);
      cmp_field("desc_flag_bits",     want.desc_flag_bits,     got.desc_flag_bits);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;
  logic        push;
  logic        full;
  in_item_t    in_data;
  logic        empty;
  logic        pop;
  out_item_t   out_data;

  nbr_fsm_tracker tracker;

  bit idle_on;        // random gaps and stalls allowed on both sides
  bit hold_req;       // asks the receiver for its long hold-off
  int n_sent;
  int n_settings;
  int full_cycles;    // edges at which a pending transaction met a full queue

  ospf_neighbor_fsm_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offers one event and holds it until the queue takes it. push is left high
  // so back-to-back transactions need no second assignment in one step.
  task automatic send_event(input in_item_t ev_item);
    int gap;
    in_data <= ev_item;
    push    <= 1'b1;
    do begin
      @(posedge clk);
      if (full) full_cycles++;
    end while (full);
    tracker.note_event(ev_item);
    n_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender pauses until every outstanding result has been popped.
  task automatic drain();
    push <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Writes all three registers back to back; only called with the block idle.
  task automatic apply_setting(input logic [2:0] kind, input logic [31:0] own,
                               input logic [31:0] nbr);
    logic [31:0] vals [3];
    vals[0] = {29'd0, kind};
    vals[1] = own;
    vals[2] = nbr;
    for (int r = 0; r < 3; r++) begin
      cfg_index <= cfg_reg_e'(r);
      cfg_data  <= vals[r];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      tracker.set_reg(cfg_reg_e'(r), vals[r]);
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  function automatic in_item_t mk_event(ev_e ev, logic [31:0] dr, logic [31:0] bdr,
                                        logic [31:0] ndr, logic [31:0] nbdr,
                                        logic [31:0] now, logic req_empty);
    in_item_t it;
    it.opcode             = ev;
    it.iface_dr           = dr;
    it.iface_bdr          = bdr;
    it.nbr_dr             = ndr;
    it.nbr_bdr            = nbdr;
    it.time_now           = now;
    it.request_list_empty = req_empty;
    return it;
  endfunction

  // Address that matches the configured one often enough to flip adjacency
  function automatic logic [31:0] pick_addr(logic [31:0] match);
    case ($urandom_range(0, 9))
      0, 1:    return match;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Event that moves the neighbour on from the given state; in Full, a random one, mostly one that leaves Full.
  function automatic ev_e next_useful(nbr_state_e st);
    case (st)
      NS_DOWN:     return $urandom_range(0, 1) ? EV_HELLO : EV_START;
      NS_ATTEMPT:  return EV_HELLO;
      NS_INIT:     return EV_TWOWAY;
      NS_TWOWAY:   return EV_ADJ_OK;
      NS_EXSTART:  return EV_NEG_DONE;
      NS_EXCHANGE: return EV_EXCH_DONE;
      NS_LOADING:  return EV_LOAD_DONE;
      default: begin
        case ($urandom_range(0, 7))
          0, 1:    return EV_HELLO;
          2:       return EV_ADJ_OK;
          3:       return EV_SEQ_MISMTCH;
          4:       return EV_BAD_LSREQ;
          5:       return EV_ONEWAY;
          6:       return EV_INACTIVITY;
          default: return $urandom_range(0, 1) ? EV_KILL : EV_LL_DOWN;
        endcase
      end
    endcase
  endfunction

  // Mostly well-formed progress from the tracked state, the rest any opcode
  function automatic in_item_t random_event();
    in_item_t it;
    if ($urandom_range(0, 9) < 7) it.opcode = next_useful(tracker.state);
    else                          it.opcode = 4'($urandom_range(0, 15));
    it.iface_dr           = pick_addr(tracker.own);
    it.iface_bdr          = pick_addr(tracker.own);
    it.nbr_dr             = pick_addr(tracker.nbr);
    it.nbr_bdr            = pick_addr(tracker.nbr);
    it.time_now           = pick_addr('1);
    it.request_list_empty = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver side: random stall bursts, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int stall_left;
    int hold_left;
    bit hold_done;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    pop <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (pop && !empty) tracker.check_step(out_data);
      if (hold_req && !hold_done) begin
        hold_left = RX_HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [2:0] kinds [NUM_PHASES];
    logic [31:0] own;
    logic [31:0] nbr;
    tracker = new();
    tracker.reset_model();
    idle_on     = 1'b1;
    hold_req    = 1'b0;
    n_sent      = 0;
    n_settings  = 0;
    full_cycles = 0;
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_IFACE_KIND;
    cfg_data  <= '0;
    push      <= 1'b0;
    in_data   <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed walk: every event, both adjacency outcomes, both exchange exits,
    // sequence seeding, 32-bit wrap, empty opcodes and teardown from Full.
    apply_setting(IFACE_BCAST, OWN_A, NBR_A);
    send_event(mk_event(EV_NONE,      '0, '0, '0, '0, 32'd5, 1'b0));
    send_event(mk_event(EV_HELLO,     '1, '1, '1, '1, 32'd5, 1'b1));
    send_event(mk_event(EV_START,     '0, '1, '0, '1, 32'd5, 1'b0));
    send_event(mk_event(EV_TWOWAY,    OTHER_A, '0, '1, OTHER_A, 32'd7, 1'b0));
    send_event(mk_event(EV_ADJ_OK,    OWN_A, '0, '0, '0, '1, 1'b0));     // seeds seq
    send_event(mk_event(EV_NEG_DONE,  '0, '0, '0, '0, 32'd0, 1'b0));
    send_event(mk_event(EV_EXCH_DONE, '0, '0, '0, '0, 32'd0, 1'b0));    // to Loading
    send_event(mk_event(EV_BAD_LSREQ, '0, '0, '0, '0, 32'd0, 1'b0));
    send_event(mk_event(EV_NEG_DONE,  '0, '0, '0, '0, 32'd0, 1'b1));
    send_event(mk_event(EV_EXCH_DONE, '0, '0, '0, '0, 32'd0, 1'b1));    // to Full
    send_event(mk_event(EV_SEQ_MISMTCH, '0, '0, '0, '0, 32'd0, 1'b0));
    send_event(mk_event(EV_ADJ_OK,    '0, '0, '0, '0, 32'd0, 1'b0));    // adjacency lost
    send_event(mk_event(EV_ADJ_OK,    '0, '0, '0, NBR_A, 32'd9, 1'b0)); // seq wraps to 0
    send_event(mk_event(EV_ONEWAY,    '0, '0, '0, '0, 32'd0, 1'b0));
    send_event(mk_event(EV_TWOWAY,    '0, OWN_A, NBR_A, '0, 32'd0, 1'b0));
    send_event(mk_event(EV_NEG_DONE,  '0, '0, '0, '0, 32'd0, 1'b0));
    send_event(mk_event(EV_EXCH_DONE, '0, '0, '0, '0, 32'd0, 1'b0));
    send_event(mk_event(EV_LOAD_DONE, '0, '0, '0, '0, 32'd0, 1'b0));
    send_event(mk_event(EV_HELLO,     '0, '0, '0, '0, 32'd0, 1'b0));
    send_event(mk_event(ev_e'(4'd14), '1, '1, '1, '1, '1, 1'b1));
    send_event(mk_event(ev_e'(4'd15), '1, '1, '1, '1, '1, 1'b1));
    send_event(mk_event(EV_INACTIVITY, '0, '0, '0, '0, 32'd0, 1'b0));
    send_event(mk_event(EV_START,     '0, '0, '0, '0, 32'd0, 1'b0));
    send_event(mk_event(EV_KILL,      '0, '0, '0, '0, 32'd0, 1'b0));
    send_event(mk_event(EV_LL_DOWN,   '0, '0, '0, '0, 32'd0, 1'b0));
    drain();

    // Back-pressure: receiver holds off while events keep coming, so the
    // queues fill and full must stall the input. Then a full drain.
    apply_setting(IFACE_P2P, $urandom(), $urandom());
    idle_on  = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < PRESSURE_EVENTS; i++) send_event(random_event());
    drain();

    // Random phases over interface kinds, the undefined ones and address extremes
    kinds[0] = IFACE_BCAST;
    kinds[1] = IFACE_NBMA;
    kinds[2] = IFACE_P2P;
    kinds[3] = IFACE_P2MP;
    kinds[4] = IFACE_VLINK;
    kinds[5] = IFACE_UNDEF_LO;
    kinds[6] = IFACE_UNDEF_HI;
    kinds[7] = IFACE_BCAST;
    for (int p = 0; p < NUM_PHASES; p++) begin
      own = (p == 1) ? 32'd0 : (p == 2) ? '1 : $urandom();
      nbr = (p == 1) ? '1 : (p == 2) ? 32'd0 : $urandom();
      apply_setting(kinds[p], own, nbr);
      // a phase without gaps now and then; none at all in the last one
      idle_on = (p % 3 != 2) && (p != NUM_PHASES - 1);
      for (int i = 0; i < PHASE_EVENTS; i++) send_event(random_event());
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d neighbour events over %0d interface settings, %0d results checked.",
             n_sent, n_settings, tracker.n_checked);
    $display("Input held off by a full queue on %0d edges; %0d mismatches, %0d still outstanding.",
             full_cycles, tracker.mismatches, tracker.pending());
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/onfsm_pkg.sv
rtl/onfsm_front.sv
rtl/onfsm_cmd_q.sv
rtl/onfsm_back.sv
rtl/ospf_neighbor_fsm_core.sv
tb/ospf_neighbor_fsm_core_test.sv
